// ===== src/pac_pkg.sv =====
// Package for the polygon area and centroid block.
// Holds default parameter values, the queue depth and the back-end state type.
// No dependencies.
package pac_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_WIDTH_DEF  = 16;

  // Depth of the queue of finished polygon sums between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } pac_back_state_t;

endpackage

// ===== src/pac_queue.sv =====
// Small FIFO of finished polygon sums between the front and the back end.
// Depends on pac_pkg for its depth.
module pac_queue #(
  parameter int WIDTH = 156
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         pop_data,
  output logic                     nonempty,
  output logic [pac_pkg::QC_W-1:0] count
);
  import pac_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic             do_pop;

  assign nonempty = (count != '0);
  assign do_pop   = pop && nonempty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QC_W'(push) - QC_W'(do_pop);
    end
  end

endmodule

// ===== src/pac_front.sv =====
// Front end: accepts vertex words, forms polygon edges, runs the cross-product
// and moment pipeline and accumulates the sums. Depends on pac_pkg.
module pac_front #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,
  input  logic [pac_pkg::QC_W-1:0]             q_count,
  output logic                                 push,
  output logic [2*(3*COORD_WIDTH+9)+(2*COORD_WIDTH+9):0] push_data
);
  import pac_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int AREA_W = 2 * CW + 9;
  localparam int MOM_W  = 3 * CW + 9;
  localparam int CROSS_W = 2 * CW + 1;
  localparam int MP_W   = 3 * CW + 2;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 6) + 1;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_VERTICES + 1);

  logic signed [CW-1:0] in_x, in_y;
  logic                 accept;
  logic [CNT_W-1:0]     vcount, cnt_inc;
  logic signed [CW-1:0] first_x, first_y, prev_x, prev_y;
  logic                 pending, pend_many;

  // Edge issue stage
  logic                 e_valid, e_close, e_many;
  logic signed [CW-1:0] e_ax, e_ay, e_bx, e_by;
  // Product stage
  logic                    s1_valid, s1_close, s1_many;
  logic signed [2*CW-1:0]  s1_p1, s1_p2;
  logic signed [CW:0]      s1_sx, s1_sy;
  // Cross-product stage
  logic                     s2_valid, s2_close, s2_many;
  logic signed [CROSS_W-1:0] s2_c;
  logic signed [CW:0]       s2_sx, s2_sy;
  // Moment product stage
  logic                     s3_valid, s3_close, s3_many;
  logic signed [CROSS_W-1:0] s3_c;
  logic signed [MP_W-1:0]   s3_mx, s3_my;

  logic [AREA_W-1:0] acc_s, s_new;
  logic [MOM_W-1:0]  acc_mx, acc_my, mx_new, my_new;
  logic [OCC_W-1:0]  occupancy;

  assign in_x   = s_axis_tdata[CW-1:0];
  assign in_y   = s_axis_tdata[2*CW-1:CW];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cnt_inc = (vcount < CNT_SAT) ? vcount + 1'b1 : vcount;

  // Every polygon close still in flight will need one queue slot.
  assign occupancy = OCC_W'(q_count) + OCC_W'(pending) + OCC_W'(e_valid && e_close)
                   + OCC_W'(s1_valid && s1_close) + OCC_W'(s2_valid && s2_close)
                   + OCC_W'(s3_valid && s3_close);
  assign s_axis_tready = !pending && (occupancy < OCC_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount  <= '0;
      pending <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (pending) begin
        // Closing edge from the last vertex back to the first one.
        e_valid <= 1'b1;
        pending <= 1'b0;
      end else if (accept) begin
        e_valid <= (vcount != '0);
        if (s_axis_tlast) begin
          pending <= 1'b1;
          vcount  <= '0;
        end else begin
          vcount <= cnt_inc;
        end
      end else begin
        e_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      e_close <= 1'b1;
      e_many  <= pend_many;
      e_ax    <= prev_x;
      e_ay    <= prev_y;
      e_bx    <= first_x;
      e_by    <= first_y;
    end else if (accept) begin
      if (vcount == '0) begin
        first_x <= in_x;
        first_y <= in_y;
      end
      e_close   <= 1'b0;
      e_many    <= 1'b0;
      e_ax      <= prev_x;
      e_ay      <= prev_y;
      e_bx      <= in_x;
      e_by      <= in_y;
      prev_x    <= in_x;
      prev_y    <= in_y;
      pend_many <= (cnt_inc == CNT_SAT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= e_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_close <= e_close;
    s1_many  <= e_many;
    s1_p1    <= e_ax * e_by;
    s1_p2    <= e_bx * e_ay;
    s1_sx    <= (CW+1)'(e_ax) + (CW+1)'(e_bx);
    s1_sy    <= (CW+1)'(e_ay) + (CW+1)'(e_by);

    s2_close <= s1_close;
    s2_many  <= s1_many;
    s2_c     <= CROSS_W'(s1_p1) - CROSS_W'(s1_p2);
    s2_sx    <= s1_sx;
    s2_sy    <= s1_sy;

    s3_close <= s2_close;
    s3_many  <= s2_many;
    s3_c     <= s2_c;
    s3_mx    <= s2_sx * s2_c;
    s3_my    <= s2_sy * s2_c;
  end

  assign s_new  = acc_s + AREA_W'(s3_c);
  assign mx_new = acc_mx + MOM_W'(s3_mx);
  assign my_new = acc_my + MOM_W'(s3_my);

  assign push      = s3_valid && s3_close;
  assign push_data = {s3_many, my_new, mx_new, s_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_s  <= '0;
      acc_mx <= '0;
      acc_my <= '0;
    end else if (s3_valid) begin
      if (s3_close) begin
        acc_s  <= '0;
        acc_mx <= '0;
        acc_my <= '0;
      end else begin
        acc_s  <= s_new;
        acc_mx <= mx_new;
        acc_my <= my_new;
      end
    end
  end

endmodule

// ===== src/pac_back.sv =====
// Back end: takes finished sums from the queue, forms the area, divides the
// moment sums by three times the signed doubled area and holds the result word.
// Depends on pac_pkg.
module pac_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [2*(3*COORD_WIDTH+9)+(2*COORD_WIDTH+9):0] q_data,
  input  logic                                          q_valid,
  output logic                                          q_pop,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // area, centroid_x, centroid_y from bit 0 up, zero filled
  output logic [((4*COORD_WIDTH+14)/8)*8-1:0]           m_axis_tdata,
  // degenerate, too_many_vertices from bit 0 up
  output logic [1:0]                                    m_axis_tuser
);
  import pac_pkg::*;

  localparam int CW         = COORD_WIDTH;
  localparam int AREA_W     = 2 * CW + 9;
  localparam int AREA_OUT_W = AREA_W - 2;
  localparam int MOM_W      = 3 * CW + 9;
  localparam int DV_W       = AREA_W + 2;
  localparam int STEP_W     = $clog2(MOM_W);
  localparam logic [MOM_W-1:0] POS_LIM = MOM_W'((1 << (CW - 1)) - 1);
  localparam logic [MOM_W-1:0] NEG_LIM = MOM_W'(1 << (CW - 1));

  pac_back_state_t state, state_next;

  logic signed [AREA_W-1:0] q_s;
  logic signed [MOM_W-1:0]  q_mx, q_my;
  logic                     q_many;
  logic [AREA_W-1:0]        q_mag, q_half;

  logic                  div_run, out_load, out_free, last_step;
  logic [STEP_W-1:0]     step;
  logic [DV_W-1:0]       divisor, rem_x, rem_y, rem_x_next, rem_y_next;
  logic [DV_W:0]         trial_x, trial_y;
  logic                  bit_x, bit_y;
  logic [MOM_W-1:0]      num_x, num_y;
  logic                  neg_x, neg_y, degen, many;
  logic [AREA_OUT_W-1:0] area_r;

  logic [AREA_OUT_W-1:0] out_area;
  logic [CW-1:0]         out_cx, out_cy;
  logic                  out_degen, out_many;

  function automatic logic [CW-1:0] saturate(input logic [MOM_W-1:0] q, input logic neg);
    logic [MOM_W-1:0] nq;
    logic [CW-1:0]    r;
    nq = -q;
    if (neg) begin
      r = (q > NEG_LIM) ? {1'b1, {(CW-1){1'b0}}} : nq[CW-1:0];
    end else begin
      r = (q > POS_LIM) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end
    return r;
  endfunction

  assign q_s    = q_data[AREA_W-1:0];
  assign q_mx   = q_data[AREA_W+MOM_W-1:AREA_W];
  assign q_my   = q_data[AREA_W+2*MOM_W-1:AREA_W+MOM_W];
  assign q_many = q_data[AREA_W+2*MOM_W];
  assign q_mag  = q_s[AREA_W-1] ? AREA_W'(-q_s) : AREA_W'(q_s);
  assign q_half = q_mag >> 1;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign last_step = (step == STEP_W'(MOM_W - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid) state_next = (q_s == '0) ? BK_FINISH : BK_DIVIDE;
      BK_DIVIDE: if (last_step) state_next = BK_FINISH;
      BK_FINISH: if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    unique case (state)
      BK_IDLE:   q_pop = q_valid;
      BK_DIVIDE: div_run = 1'b1;
      BK_FINISH: out_load = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring step per cycle on each moment, sharing the divisor.
  assign trial_x    = {rem_x, num_x[MOM_W-1]};
  assign trial_y    = {rem_y, num_y[MOM_W-1]};
  assign bit_x      = (trial_x >= {1'b0, divisor});
  assign bit_y      = (trial_y >= {1'b0, divisor});
  assign rem_x_next = bit_x ? DV_W'(trial_x - {1'b0, divisor}) : trial_x[DV_W-1:0];
  assign rem_y_next = bit_y ? DV_W'(trial_y - {1'b0, divisor}) : trial_y[DV_W-1:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      divisor <= DV_W'(q_mag) + (DV_W'(q_mag) << 1);
      num_x   <= q_mx[MOM_W-1] ? MOM_W'(-q_mx) : MOM_W'(q_mx);
      num_y   <= q_my[MOM_W-1] ? MOM_W'(-q_my) : MOM_W'(q_my);
      neg_x   <= q_mx[MOM_W-1] ^ q_s[AREA_W-1];
      neg_y   <= q_my[MOM_W-1] ^ q_s[AREA_W-1];
      degen   <= (q_s == '0);
      many    <= q_many;
      area_r  <= q_half[AREA_OUT_W] ? {AREA_OUT_W{1'b1}} : q_half[AREA_OUT_W-1:0];
      rem_x   <= '0;
      rem_y   <= '0;
      step    <= '0;
    end else if (div_run) begin
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
      num_x <= {num_x[MOM_W-2:0], bit_x};
      num_y <= {num_y[MOM_W-2:0], bit_y};
      step  <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_area  <= area_r;
      out_cx    <= degen ? '0 : saturate(num_x, neg_x);
      out_cy    <= degen ? '0 : saturate(num_y, neg_y);
      out_degen <= degen;
      out_many  <= many;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[AREA_OUT_W-1:0]                   = out_area;
    m_axis_tdata[AREA_OUT_W+CW-1:AREA_OUT_W]       = out_cx;
    m_axis_tdata[AREA_OUT_W+2*CW-1:AREA_OUT_W+CW]  = out_cy;
  end

  assign m_axis_tuser = {out_many, out_degen};

endmodule

// ===== src/polygon_area_centroid.sv =====
// Polygon area and centroid by the shoelace formula, streaming vertices in.
// Throughput: one vertex word per cycle while the queue has room; no vertex is
// taken while the closing edge of a polygon is issued. The back end runs each
// polygon through its shared bit-serial divider loop; a four-entry queue absorbs
// bursts of short polygons.
// Reset (synchronous, rst high) empties the pipeline and queue and clears the sums.
module polygon_area_centroid #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pac_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // vertex_x, vertex_y from bit 0 up
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // last_vertex
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // area, centroid_x, centroid_y from bit 0 up, zero filled
  output logic [((4*COORD_WIDTH+14)/8)*8-1:0] m_axis_tdata,
  // degenerate, too_many_vertices from bit 0 up
  output logic [1:0]                          m_axis_tuser
);
  import pac_pkg::*;

  localparam int Q_W = 2 * (3 * COORD_WIDTH + 9) + (2 * COORD_WIDTH + 9) + 1;

  logic            push, pop, q_nonempty;
  logic [Q_W-1:0]  push_data, pop_data;
  logic [QC_W-1:0] q_count;

  pac_front #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .q_count      (q_count),
    .push         (push),
    .push_data    (push_data)
  );

  pac_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  pac_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (pop_data),
    .q_valid      (q_nonempty),
    .q_pop        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
